@@ sv/mqpd_pkg.sv @@
// mqpd_pkg: types, character constants and lookup functions for the
// encoded-word decoder. No dependencies.
`timescale 1ns / 1ps

package mqpd_pkg;

    localparam int OUT_CNT_W = 12;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [5:0] B64_PLUS  = 6'd62;
    localparam logic [5:0] B64_SLASH = 6'd63;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ESC  = 2'd1,
        PH_HEX  = 2'd2,
        PH_DROP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef struct packed {
        logic                 valid;
        logic [7:0]           data;
        t_kind                kind;
        logic [OUT_CNT_W-1:0] count;
        logic                 last;
    } t_result;

    // {ok, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // {ok, value}
    function automatic logic [6:0] b64_value(input logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c inside {[8'h41:8'h5A]}) begin
            r = {1'b1, 6'(c - 8'h41)};
        end else if (c inside {[8'h61:8'h7A]}) begin
            r = {1'b1, 6'(c - 8'h47)};
        end else if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 6'(c + 8'h04)};
        end else if (c == CH_PLUS) begin
            r = {1'b1, B64_PLUS};
        end else if (c == CH_SLASH) begin
            r = {1'b1, B64_SLASH};
        end
        return r;
    endfunction

endpackage

@@ sv/mqpd_core.sv @@
// mqpd_core: per-word decode state and the one-byte step for both modes.
// Depends on mqpd_pkg.
`timescale 1ns / 1ps

module mqpd_core #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    output mqpd_pkg::t_result  o_res
);

    localparam int EXT_W = (COUNT_WIDTH > mqpd_pkg::OUT_CNT_W) ? COUNT_WIDTH
                                                               : mqpd_pkg::OUT_CNT_W;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic                   r_mode;
    mqpd_pkg::t_phase       r_phase, n_phase;
    logic [3:0]             r_nib, n_nib;
    logic [11:0]            r_pool, n_pool;
    logic [3:0]             r_bits, n_bits;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   term;
    logic [4:0]             hex;
    logic [6:0]             b64;
    logic [11:0]            pool_sh;
    logic [3:0]             bits_add;
    logic [3:0]             rem;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic [EXT_W-1:0]       cur_ext, inc_ext;
    logic                   err;

    always_comb begin
        term      = (i_byte == mqpd_pkg::CH_QMARK) || (i_byte == mqpd_pkg::CH_NUL);
        hex       = mqpd_pkg::hex_value(i_byte);
        b64       = mqpd_pkg::b64_value(i_byte);
        pool_sh   = {r_pool[5:0], b64[5:0]};
        bits_add  = r_bits + 4'd6;
        rem       = bits_add - 4'd8;
        count_inc = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;
        cur_ext   = EXT_W'(r_count);
        inc_ext   = EXT_W'(count_inc);

        n_phase = r_phase;
        n_nib   = r_nib;
        n_pool  = r_pool;
        n_bits  = r_bits;
        n_count = r_count;
        err     = 1'b0;

        o_res.valid = 1'b0;
        o_res.data  = 8'h00;
        o_res.kind  = mqpd_pkg::KIND_BYTE;
        o_res.count = inc_ext[mqpd_pkg::OUT_CNT_W-1:0];
        o_res.last  = 1'b0;

        if (r_mode) begin
            if (term) begin
                o_res.valid = 1'b1;
                o_res.kind  = mqpd_pkg::KIND_OK;
                o_res.count = cur_ext[mqpd_pkg::OUT_CNT_W-1:0];
                o_res.last  = 1'b1;
                n_phase = mqpd_pkg::PH_IDLE;
                n_nib   = 4'd0;
                n_pool  = 12'd0;
                n_bits  = 4'd0;
                n_count = '0;
            end else if (b64[6]) begin
                n_pool = pool_sh;
                n_bits = bits_add;
                if (bits_add >= 4'd8) begin
                    // six new bits complete a byte; keep the remainder
                    n_bits      = rem;
                    o_res.valid = 1'b1;
                    o_res.data  = 8'(pool_sh >> rem);
                    n_pool      = pool_sh & ((12'd1 << rem) - 12'd1);
                    n_count     = count_inc;
                end
            end
        end else begin
            case (r_phase)
                mqpd_pkg::PH_ESC: begin
                    if (i_byte == mqpd_pkg::CH_CR || i_byte == mqpd_pkg::CH_LF) begin
                        n_phase = mqpd_pkg::PH_IDLE;
                    end else if (hex[4]) begin
                        n_nib   = hex[3:0];
                        n_phase = mqpd_pkg::PH_HEX;
                    end else begin
                        err = 1'b1;
                    end
                end
                mqpd_pkg::PH_HEX: begin
                    if (hex[4]) begin
                        n_phase     = mqpd_pkg::PH_IDLE;
                        n_nib       = 4'd0;
                        o_res.valid = 1'b1;
                        o_res.data  = {r_nib, hex[3:0]};
                        n_count     = count_inc;
                    end else begin
                        err = 1'b1;
                    end
                end
                mqpd_pkg::PH_DROP: begin
                    if (term) begin
                        n_phase = mqpd_pkg::PH_IDLE;
                        n_nib   = 4'd0;
                        n_pool  = 12'd0;
                        n_bits  = 4'd0;
                        n_count = '0;
                    end
                end
                default: begin
                    if (term) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = mqpd_pkg::KIND_OK;
                        o_res.count = cur_ext[mqpd_pkg::OUT_CNT_W-1:0];
                        o_res.last  = 1'b1;
                        n_phase = mqpd_pkg::PH_IDLE;
                        n_nib   = 4'd0;
                        n_pool  = 12'd0;
                        n_bits  = 4'd0;
                        n_count = '0;
                    end else if (i_byte == mqpd_pkg::CH_EQ) begin
                        n_phase = mqpd_pkg::PH_ESC;
                    end else begin
                        o_res.valid = 1'b1;
                        o_res.data  = (i_byte == mqpd_pkg::CH_UNDER) ? mqpd_pkg::CH_SPACE
                                                                      : i_byte;
                        n_count     = count_inc;
                    end
                end
            endcase

            // bad or missing hex digit: report, then swallow up to the terminator
            if (err) begin
                o_res.valid = 1'b1;
                o_res.kind  = mqpd_pkg::KIND_ERR;
                o_res.count = cur_ext[mqpd_pkg::OUT_CNT_W-1:0];
                o_res.last  = 1'b1;
                n_phase = term ? mqpd_pkg::PH_IDLE : mqpd_pkg::PH_DROP;
                n_nib   = 4'd0;
                n_pool  = 12'd0;
                n_bits  = 4'd0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_phase <= mqpd_pkg::PH_IDLE;
            r_nib   <= 4'd0;
            r_pool  <= 12'd0;
            r_bits  <= 4'd0;
            r_count <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (i_step) begin
                r_phase <= n_phase;
                r_nib   <= n_nib;
                r_pool  <= n_pool;
                r_bits  <= n_bits;
                r_count <= n_count;
            end
        end
    end

endmodule

@@ sv/mime_qp_base64_word_decoder_top.sv @@
// Top level of the encoded-word decoder: input handshake, result register.
// Depends on mqpd_pkg and mqpd_core.
// A result is registered and is valid in the cycle after the input transfer that causes it.
// Throughput: one input byte per cycle; the registered state update in
// mqpd_core sets this, and the result register lets a new byte in while a
// result waits as long as the output side takes it in the same cycle.
// Reset (synchronous, active low) clears the mode, all word state and the result valid.
`timescale 1ns / 1ps

module mime_qp_base64_word_decoder_top #(
    parameter int COUNT_WIDTH = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_kind,
    output logic [11:0] o_byte_count,
    output logic        o_last
);

    mqpd_pkg::t_result res;
    mqpd_pkg::t_result r_out;
    logic              r_out_valid;
    logic              accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    mqpd_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_step     (accept),
        .i_byte     (i_in_byte),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload loads on every transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out.data;
    assign o_kind       = r_out.kind;
    assign o_byte_count = r_out.count;
    assign o_last       = r_out.last;

endmodule
